[hw/rtl/grmc_pkg.sv]
package grmc_pkg;

    localparam int MAP_DIM    = 64;
    localparam int MAP_CELLS  = MAP_DIM * MAP_DIM;
    localparam int MAP_AW     = $clog2(MAP_CELLS);
    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = 22;
    localparam int RAY_W      = 24;
    localparam int STEP_W     = 11;
    localparam int TRIG_W     = 31;
    localparam int QUAD_SPAN  = 256;
    localparam int DIV_STEPS  = 26;
    localparam int SQRT_STEPS = 23;

    localparam logic [13:0] STEP_LIMIT  = 14'd16383;
    localparam logic [15:0] THIRTY_DEG  = 16'd5461;
    localparam logic [15:0] QUARTER     = 16'd16384;
    localparam logic [25:0] SPAN_NUM    = 26'(400 * (1 << FRAC_BITS));

    localparam longint unsigned STEP_DEN = 64'd100 << 30;

    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_MAP_WIDTH     = 3'd2;
    localparam logic [2:0] CFG_MAP_HEIGHT    = 3'd3;
    localparam logic [2:0] CFG_WALL_COLOR    = 3'd4;
    localparam logic [2:0] CFG_SPECIAL_COLOR = 3'd5;

    localparam logic [1:0] CELL_WALL    = 2'd1;
    localparam logic [1:0] CELL_SPECIAL = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ANGLE_DIV,
        ST_SETUP,
        ST_MARCH_CHK,
        ST_MARCH_RD,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_ADD,
        ST_SQRT,
        ST_SCALE,
        ST_SCALE_CHK,
        ST_HALF_DIV,
        ST_HALF_FIN,
        ST_DONE
    } state_t;

    typedef logic [TRIG_W-1:0] sin_tab_t [0:QUAD_SPAN];
    typedef logic [9:0]        step_tab_t [0:QUAD_SPAN];

    typedef struct packed {
        logic       neg;
        logic [8:0] idx;
    } trig_sel_t;

    function automatic longint unsigned sin_q30(int unsigned idx);
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        r  = longint'(idx) * 64;
        x  = (r * 64'd1686629713) >> 14;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824 - x2 / 72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    function automatic sin_tab_t build_sin();
        sin_tab_t tab;
        for (int i = 0; i <= QUAD_SPAN; i++)
        begin
            tab[i] = TRIG_W'(sin_q30(i));
        end
        return tab;
    endfunction

    function automatic step_tab_t build_step();
        step_tab_t tab;
        for (int i = 0; i <= QUAD_SPAN; i++)
        begin
            tab[i] = 10'(((sin_q30(i) << FRAC_BITS) + STEP_DEN / 2) / STEP_DEN);
        end
        return tab;
    endfunction

    localparam sin_tab_t  SIN_TAB  = build_sin();
    localparam step_tab_t STEP_TAB = build_step();

    // quarter-wave index and sign of a binary angle, 1024 steps per turn
    function automatic trig_sel_t trig_sel(logic [15:0] a);
        trig_sel_t s;
        s.neg = a[15];
        s.idx = a[14] ? (9'd256 - {1'b0, a[13:6]}) : {1'b0, a[13:6]};
        return s;
    endfunction

endpackage

[hw/rtl/grid_ray_march_column_core.sv]
// Write item: stored into the map, no result.
// Cast item: angle division and setup, march steps through the map memory (up to 16384
// steps), then square root, scaling, division and result hand-off on one shared subtract
// unit and one multiplier. One cast at a time. Reset: asynchronous, active low; control and
// configuration registers return to defaults, then a clearing pass over all 4096 map
// cells empties the map, during which no item is taken.
module grid_ray_march_column_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_row, cell_col, cell_value, screen_column, pos_x, pos_y, view_angle, zero pad
    input  logic [87:0] s_axis_tdata,
    // opcode
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_column, hit, wall_kind, half_span, color, zero pad
    output logic [55:0] m_axis_tdata
);

    grmc_pkg::state_t state_reg, state_next;

    logic [10:0] screen_width_reg, screen_height_reg;
    logic [6:0]  map_width_reg, map_height_reg;
    logic [31:0] wall_color_reg, special_color_reg;

    logic [grmc_pkg::MAP_AW-1:0] clr_cnt_reg;
    logic [4:0]  cnt_reg;
    logic [13:0] march_steps_reg;

    logic [9:0]  col_reg;
    logic [21:0] px_reg, py_reg;
    logic [15:0] view_reg;
    logic [6:0]  mw_reg, mh_reg;
    logic [25:0] num_reg;
    logic [23:0] den_reg;
    logic [25:0] rem_reg;
    logic [22:0] root_reg;
    logic [45:0] sq_reg;
    logic [53:0] prod_reg, sum_reg;
    logic signed [grmc_pkg::STEP_W-1:0] step_x_reg, step_y_reg;
    logic signed [grmc_pkg::RAY_W-1:0]  ray_x_reg, ray_y_reg;
    logic [grmc_pkg::TRIG_W-1:0] cos_reg;
    logic        cos_pos_reg;
    logic [1:0]  kind_reg;
    logic [9:0]  half_reg;

    logic        out_valid_reg;
    logic [55:0] out_data_reg;

    logic        in_acc, is_cast;
    logic [5:0]  in_row, in_col;
    logic [1:0]  in_val;
    logic [9:0]  in_scol;
    logic [21:0] in_px, in_py;
    logic [15:0] in_view;

    logic        ram_we;
    logic [grmc_pkg::MAP_AW-1:0] ram_waddr, ram_raddr;
    logic [1:0]  ram_wdata, ram_rdata;

    logic [25:0] sub_a, sub_b, sub_diff;
    logic        sub_ge;
    logic [22:0] mul_a;
    logic [30:0] mul_b;

    logic [10:0] w_eff;
    logic [15:0] delta, ang;
    grmc_pkg::trig_sel_t sel_x, sel_y, sel_d;
    logic [9:0]  mag_x, mag_y;
    logic        ray_in_map;
    logic signed [grmc_pkg::RAY_W-1:0] dx, dy;
    logic [21:0] ux, uy;
    logic [23:0] corr_dist;
    logic        last_iter, out_free;

    assign cfg_ready     = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_cast       = s_axis_tuser[0];
    assign in_row        = s_axis_tdata[5:0];
    assign in_col        = s_axis_tdata[11:6];
    assign in_val        = s_axis_tdata[13:12];
    assign in_scol       = s_axis_tdata[23:14];
    assign in_px         = s_axis_tdata[45:24];
    assign in_py         = s_axis_tdata[67:46];
    assign in_view       = s_axis_tdata[83:68];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign last_iter     = (cnt_reg == 5'd1);

    assign w_eff = (screen_width_reg == 11'd0) ? 11'd1 : screen_width_reg;
    assign delta = num_reg[15:0] - grmc_pkg::THIRTY_DEG;
    assign ang   = view_reg + delta;
    assign sel_x = grmc_pkg::trig_sel(ang + grmc_pkg::QUARTER);
    assign sel_y = grmc_pkg::trig_sel(ang);
    assign sel_d = grmc_pkg::trig_sel(delta + grmc_pkg::QUARTER);
    assign mag_x = grmc_pkg::STEP_TAB[sel_x.idx];
    assign mag_y = grmc_pkg::STEP_TAB[sel_y.idx];

    assign ray_in_map = !ray_x_reg[grmc_pkg::RAY_W-1] && !ray_y_reg[grmc_pkg::RAY_W-1]
                        && (ray_x_reg[22:0] < {mw_reg, 16'd0})
                        && (ray_y_reg[22:0] < {mh_reg, 16'd0});

    assign dx   = ray_x_reg - $signed({2'b00, px_reg});
    assign dy   = ray_y_reg - $signed({2'b00, py_reg});
    assign ux   = dx[grmc_pkg::RAY_W-1] ? 22'(-dx) : dx[21:0];
    assign uy   = dy[grmc_pkg::RAY_W-1] ? 22'(-dy) : dy[21:0];
    assign corr_dist = cos_pos_reg ? prod_reg[53:30] : 24'd0;

    // shared compare and subtract
    always_comb
    begin
        case (state_reg)
            grmc_pkg::ST_ANGLE_DIV, grmc_pkg::ST_HALF_DIV:
            begin
                sub_a = {1'b0, rem_reg[23:0], num_reg[25]};
                sub_b = {2'b00, den_reg};
            end
            grmc_pkg::ST_SQRT:
            begin
                sub_a = {rem_reg[23:0], sq_reg[45:44]};
                sub_b = {1'b0, root_reg, 2'b01};
            end
            default:
            begin
                sub_a = 26'd0;
                sub_b = 26'd0;
            end
        endcase
        sub_ge   = (sub_a >= sub_b);
        sub_diff = sub_a - sub_b;
    end

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            grmc_pkg::ST_SQ_X:
            begin
                mul_a = {1'b0, ux};
                mul_b = {9'd0, ux};
            end
            grmc_pkg::ST_SQ_Y:
            begin
                mul_a = {1'b0, uy};
                mul_b = {9'd0, uy};
            end
            default:
            begin
                mul_a = root_reg;
                mul_b = cos_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            grmc_pkg::ST_CLEAR:
                if (clr_cnt_reg == grmc_pkg::MAP_AW'(grmc_pkg::MAP_CELLS - 1))
                    state_next = grmc_pkg::ST_IDLE;
            grmc_pkg::ST_IDLE:
                if (in_acc && is_cast)
                    state_next = grmc_pkg::ST_ANGLE_DIV;
            grmc_pkg::ST_ANGLE_DIV:
                if (last_iter)
                    state_next = grmc_pkg::ST_SETUP;
            grmc_pkg::ST_SETUP:
                state_next = grmc_pkg::ST_MARCH_CHK;
            grmc_pkg::ST_MARCH_CHK:
                state_next = ray_in_map ? grmc_pkg::ST_MARCH_RD : grmc_pkg::ST_DONE;
            grmc_pkg::ST_MARCH_RD:
                if (ram_rdata == grmc_pkg::CELL_WALL || ram_rdata == grmc_pkg::CELL_SPECIAL)
                    state_next = grmc_pkg::ST_SQ_X;
                else if (march_steps_reg >= grmc_pkg::STEP_LIMIT)
                    state_next = grmc_pkg::ST_DONE;
                else
                    state_next = grmc_pkg::ST_MARCH_CHK;
            grmc_pkg::ST_SQ_X:
                state_next = grmc_pkg::ST_SQ_Y;
            grmc_pkg::ST_SQ_Y:
                state_next = grmc_pkg::ST_SQ_ADD;
            grmc_pkg::ST_SQ_ADD:
                state_next = grmc_pkg::ST_SQRT;
            grmc_pkg::ST_SQRT:
                if (last_iter)
                    state_next = grmc_pkg::ST_SCALE;
            grmc_pkg::ST_SCALE:
                state_next = grmc_pkg::ST_SCALE_CHK;
            grmc_pkg::ST_SCALE_CHK:
                state_next = (corr_dist == 24'd0) ? grmc_pkg::ST_DONE : grmc_pkg::ST_HALF_DIV;
            grmc_pkg::ST_HALF_DIV:
                if (last_iter)
                    state_next = grmc_pkg::ST_HALF_FIN;
            grmc_pkg::ST_HALF_FIN:
                state_next = grmc_pkg::ST_DONE;
            grmc_pkg::ST_DONE:
                if (out_free)
                    state_next = grmc_pkg::ST_IDLE;
            default:
                state_next = grmc_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == grmc_pkg::ST_IDLE);
        ram_raddr     = {ray_y_reg[21:16], ray_x_reg[21:16]};
        case (state_reg)
            grmc_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 2'd0;
            end
            grmc_pkg::ST_IDLE:
            begin
                ram_we    = in_acc && !is_cast;
                ram_waddr = {in_row, in_col};
                ram_wdata = in_val;
            end
            default:
            begin
                ram_we    = 1'b0;
                ram_waddr = {in_row, in_col};
                ram_wdata = in_val;
            end
        endcase
    end

    grmc_ram #(
        .WIDTH(2),
        .DEPTH(grmc_pkg::MAP_CELLS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= grmc_pkg::ST_CLEAR;
            clr_cnt_reg       <= '0;
            march_steps_reg   <= '0;
            out_valid_reg     <= 1'b0;
            screen_width_reg  <= 11'd320;
            screen_height_reg <= 11'd240;
            map_width_reg     <= 7'd64;
            map_height_reg    <= 7'd64;
            wall_color_reg    <= 32'hFFFF_FFFF;
            special_color_reg <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == grmc_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    grmc_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[10:0];
                    grmc_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[10:0];
                    grmc_pkg::CFG_MAP_WIDTH:     map_width_reg     <= cfg_data[6:0];
                    grmc_pkg::CFG_MAP_HEIGHT:    map_height_reg    <= cfg_data[6:0];
                    grmc_pkg::CFG_WALL_COLOR:    wall_color_reg    <= cfg_data;
                    grmc_pkg::CFG_SPECIAL_COLOR: special_color_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == grmc_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            if (state_reg == grmc_pkg::ST_SETUP)
                march_steps_reg <= '0;
            else if (state_next == grmc_pkg::ST_MARCH_CHK
                     && state_reg == grmc_pkg::ST_MARCH_RD)
                march_steps_reg <= march_steps_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            grmc_pkg::ST_IDLE:
            begin
                col_reg  <= in_scol;
                px_reg   <= in_px;
                py_reg   <= in_py;
                view_reg <= in_view;
                mw_reg   <= (map_width_reg > 7'd64) ? 7'd64 : map_width_reg;
                mh_reg   <= (map_height_reg > 7'd64) ? 7'd64 : map_height_reg;
                num_reg  <= {in_scol, 16'd0};
                den_reg  <= 24'(w_eff) * 24'd6;
                rem_reg  <= '0;
                cnt_reg  <= 5'(grmc_pkg::DIV_STEPS);
                kind_reg <= 2'd0;
                half_reg <= 10'd0;
            end
            grmc_pkg::ST_ANGLE_DIV, grmc_pkg::ST_HALF_DIV:
            begin
                rem_reg <= sub_ge ? sub_diff : sub_a;
                num_reg <= {num_reg[24:0], sub_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            grmc_pkg::ST_SETUP:
            begin
                step_x_reg  <= sel_x.neg ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
                step_y_reg  <= sel_y.neg ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
                cos_reg     <= grmc_pkg::SIN_TAB[sel_d.idx];
                cos_pos_reg <= !sel_d.neg;
                ray_x_reg   <= $signed({2'b00, px_reg});
                ray_y_reg   <= $signed({2'b00, py_reg});
            end
            grmc_pkg::ST_MARCH_RD:
            begin
                if (ram_rdata == grmc_pkg::CELL_WALL || ram_rdata == grmc_pkg::CELL_SPECIAL)
                    kind_reg <= ram_rdata;
                else
                begin
                    ray_x_reg <= ray_x_reg + grmc_pkg::RAY_W'(step_x_reg);
                    ray_y_reg <= ray_y_reg + grmc_pkg::RAY_W'(step_y_reg);
                end
            end
            grmc_pkg::ST_SQ_X:
                prod_reg <= mul_a * mul_b;
            grmc_pkg::ST_SQ_Y:
            begin
                sum_reg  <= prod_reg;
                prod_reg <= mul_a * mul_b;
            end
            grmc_pkg::ST_SQ_ADD:
            begin
                sq_reg   <= 46'(sum_reg + prod_reg);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 5'(grmc_pkg::SQRT_STEPS);
            end
            grmc_pkg::ST_SQRT:
            begin
                rem_reg  <= sub_ge ? sub_diff : sub_a;
                root_reg <= {root_reg[21:0], sub_ge};
                sq_reg   <= {sq_reg[43:0], 2'b00};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            grmc_pkg::ST_SCALE:
                prod_reg <= mul_a * mul_b;
            grmc_pkg::ST_SCALE_CHK:
            begin
                half_reg <= screen_height_reg[10:1];
                num_reg  <= grmc_pkg::SPAN_NUM + 26'(corr_dist) - 26'd1;
                den_reg  <= corr_dist;
                rem_reg  <= '0;
                cnt_reg  <= 5'(grmc_pkg::DIV_STEPS);
            end
            grmc_pkg::ST_HALF_FIN:
                if (num_reg < {16'd0, screen_height_reg[10:1]})
                    half_reg <= num_reg[9:0];
            grmc_pkg::ST_DONE:
                if (out_free)
                    out_data_reg <= {1'b0,
                                     (kind_reg == grmc_pkg::CELL_WALL) ? wall_color_reg :
                                     (kind_reg == grmc_pkg::CELL_SPECIAL) ? special_color_reg
                                                                          : 32'd0,
                                     half_reg, kind_reg, (kind_reg != 2'd0), col_reg};
            default: ;
        endcase
    end

    a_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == grmc_pkg::ST_IDLE)
        else $error("input taken outside idle");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        march_steps_reg <= grmc_pkg::STEP_LIMIT)
        else $error("march step count beyond limit");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == grmc_pkg::ST_DONE)
        else $error("result raised outside done");

    a_map_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == grmc_pkg::ST_CLEAR || state_reg == grmc_pkg::ST_IDLE))
        else $error("map written during a cast");

endmodule

[hw/rtl/grmc_ram.sv]
module grmc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
